[hw/rtl/mcat_pkg.sv]
// Shared types, request codes and constants for the multi-channel alarm table.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package mcat_pkg;

  // Sizing
  localparam int CHANNELS_DEF = 8;
  localparam int MAX_RESULTS  = 9;
  localparam int RPT_W        = $clog2(MAX_RESULTS);
  localparam int SECS_W       = 22;
  localparam int TIME_W       = 32;
  localparam int CH_W         = 8;
  localparam int MS_W         = 31;

  // Arithmetic constants
  localparam logic [SECS_W-1:0] MAX_SECS = 22'd2147484;
  localparam logic [9:0]        MS_ROUND = 10'd999;
  localparam logic [9:0]        MS_PER_S = 10'd1000;
  // floor(2^36 / 125): x / 1000 == ((x >> 3) * MS_RECIP) >> 36, minus at most one
  localparam logic [29:0]       MS_RECIP = 30'd549755813;
  localparam int                MS_SHIFT = 36;

  // Request codes
  localparam logic [2:0] REQ_SET     = 3'd0;
  localparam logic [2:0] REQ_CLEAR   = 3'd1;
  localparam logic [2:0] REQ_ENABLE  = 3'd2;
  localparam logic [2:0] REQ_DISABLE = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;
  localparam logic [2:0] REQ_TRIP    = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CH  = 2'd1;
  localparam logic [1:0] ST_BAD_INT = 2'd2;

  // Commands broadcast to the channel cells
  localparam logic [2:0] CELL_NOP     = 3'd0;
  localparam logic [2:0] CELL_SET     = 3'd1;
  localparam logic [2:0] CELL_CLEAR   = 3'd2;
  localparam logic [2:0] CELL_ENABLE  = 3'd3;
  localparam logic [2:0] CELL_DISABLE = 3'd4;
  localparam logic [2:0] CELL_TICK    = 3'd5;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [CH_W-1:0] channel;
    logic [MS_W-1:0] interval_ms;
    logic            periodic;
    logic            start_now;
    logic [TIME_W-1:0] now;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              fired;
    logic [CH_W-1:0]   fired_channel;
    logic              fired_once;
    logic              configured;
    logic              running_now;
    logic [SECS_W-1:0] next_wait;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [CH_W-1:0]   channel;
    logic [SECS_W-1:0] secs;
    logic              periodic;
    logic              start_now;
    logic [TIME_W-1:0] now;
  } cell_cmd_t;

  typedef struct packed {
    logic configured;
    logic running;
    logic fire;
  } cell_stat_t;

  // Carried down the row: running minimum wait (0 = none) and highest one-shot hit
  typedef struct packed {
    logic [SECS_W-1:0] min_wait;
    logic              once_v;
    logic [CH_W-1:0]   once_ch;
  } chain_t;

endpackage

[hw/rtl/mcat_ms2s.sv]
// Milliseconds to whole seconds, rounded up, as a three-stage reciprocal pipeline.
// Depends on mcat_pkg.
`timescale 1ns / 1ps

module mcat_ms2s (
  input  logic                       clk,
  input  logic [mcat_pkg::MS_W-1:0]  ms,
  output logic [mcat_pkg::SECS_W-1:0] secs
);
  import mcat_pkg::*;

  logic [TIME_W-1:0] x_r, x_nxt;
  logic [TIME_W-1:0] x2_r;
  logic [58:0]       prod_r;
  logic [SECS_W-1:0] secs_r, secs_nxt;
  logic [SECS_W-1:0] q0;
  logic [TIME_W-1:0] q0k;
  logic [TIME_W-1:0] rem;

  // Stage 1: bias for round-up
  assign x_nxt = {1'b0, ms} + TIME_W'(MS_ROUND);

  // Stage 3: quotient estimate is exact or one low; one compare fixes it
  always_comb begin
    q0       = prod_r[MS_SHIFT +: SECS_W];
    q0k      = (TIME_W'(q0) << 10) - (TIME_W'(q0) << 4) - (TIME_W'(q0) << 3);
    rem      = x2_r - q0k;
    secs_nxt = (rem >= TIME_W'(MS_PER_S)) ? q0 + SECS_W'(1) : q0;
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    x2_r   <= x_r;
    prod_r <= x_r[TIME_W-1:3] * MS_RECIP;
    secs_r <= secs_nxt;
  end

  assign secs = secs_r;

endmodule

[hw/rtl/mcat_cell.sv]
// One alarm channel: its state, its update on broadcast commands and one link
// of the min-wait / one-shot chain. Depends on mcat_pkg.
`timescale 1ns / 1ps

module mcat_cell #(
  parameter int CH_INDEX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mcat_pkg::cell_cmd_t    cmd,
  input  mcat_pkg::chain_t       chain_in,
  output mcat_pkg::chain_t       chain_out,
  output mcat_pkg::cell_stat_t   stat
);
  import mcat_pkg::*;

  localparam logic [CH_W-1:0] MY_CH = CH_W'(CH_INDEX);

  logic [SECS_W-1:0] interval_r, interval_nxt;
  logic [TIME_W-1:0] expiry_r, expiry_nxt;
  logic              periodic_r, periodic_nxt;
  logic              running_r, running_nxt;
  logic              fire_r, fire_nxt;
  logic              once_r, once_nxt;
  logic [SECS_W-1:0] wait_r, wait_nxt;
  chain_t            chain_r, chain_nxt;

  logic              hit;
  logic              due;
  logic [SECS_W-1:0] add_secs;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] expiry_add;
  logic [TIME_W-1:0] diff;

  // Saturating now + interval, shared by set and periodic reload
  always_comb begin
    add_secs   = (cmd.op == CELL_TICK) ? interval_r : cmd.secs;
    sum        = {1'b0, cmd.now} + {{(TIME_W + 1 - SECS_W){1'b0}}, add_secs};
    expiry_add = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  end

  // Channel state update
  always_comb begin
    hit          = (cmd.channel == MY_CH);
    due          = running_r && (expiry_r <= cmd.now);
    interval_nxt = interval_r;
    expiry_nxt   = expiry_r;
    periodic_nxt = periodic_r;
    running_nxt  = running_r;
    fire_nxt     = fire_r;
    once_nxt     = once_r;
    unique case (cmd.op)
      CELL_SET: begin
        if (hit) begin
          interval_nxt = cmd.secs;
          expiry_nxt   = expiry_add;
          periodic_nxt = cmd.periodic;
          running_nxt  = cmd.start_now;
        end
      end
      CELL_CLEAR: begin
        if (hit) begin
          interval_nxt = '0;
          expiry_nxt   = '0;
          periodic_nxt = 1'b0;
          running_nxt  = 1'b0;
        end
      end
      CELL_ENABLE: begin
        if (hit && (interval_r != '0)) running_nxt = 1'b1;
      end
      CELL_DISABLE: begin
        if (hit) running_nxt = 1'b0;
      end
      CELL_TICK: begin
        fire_nxt = due && periodic_r;
        once_nxt = due && !periodic_r;
        if (due) begin
          if (periodic_r) begin
            expiry_nxt = expiry_add;
          end else begin
            interval_nxt = '0;
            expiry_nxt   = '0;
            periodic_nxt = 1'b0;
            running_nxt  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Own remaining wait: 0 when stopped, else at least 1, capped
  always_comb begin
    diff = expiry_r - cmd.now;
    if (!running_r) begin
      wait_nxt = '0;
    end else if (expiry_r > cmd.now) begin
      wait_nxt = (diff > TIME_W'(MAX_SECS)) ? MAX_SECS : diff[SECS_W-1:0];
    end else begin
      wait_nxt = SECS_W'(1);
    end
  end

  // Chain link: merge own wait into the running minimum, later one-shot wins
  always_comb begin
    chain_nxt = chain_in;
    if (wait_r != '0 && (chain_in.min_wait == '0 || wait_r < chain_in.min_wait)) begin
      chain_nxt.min_wait = wait_r;
    end
    if (once_r) begin
      chain_nxt.once_v  = 1'b1;
      chain_nxt.once_ch = MY_CH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      expiry_r   <= '0;
      periodic_r <= 1'b0;
      running_r  <= 1'b0;
      fire_r     <= 1'b0;
      once_r     <= 1'b0;
    end else begin
      interval_r <= interval_nxt;
      expiry_r   <= expiry_nxt;
      periodic_r <= periodic_nxt;
      running_r  <= running_nxt;
      fire_r     <= fire_nxt;
      once_r     <= once_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wait_r  <= wait_nxt;
    chain_r <= chain_nxt;
  end

  assign chain_out       = chain_r;
  assign stat.configured = (interval_r != '0);
  assign stat.running    = running_r;
  assign stat.fire       = fire_r;

endmodule

[hw/rtl/multi_channel_alarm_table_top.sv]
// Multi-channel alarm table: one request at a time, results through an output
// register. A row of CHANNELS cells holds the alarm state; each set, clear, enable,
// disable or tick that is not rejected is applied to the cells in the apply state,
// then the minimum wait and the highest expired one-shot ripple down the row one
// cell per cycle, and a tick then sweeps the cells in index order, one per cycle
// unless a firing report waits on the output, to report periodic firings, followed
// by a one-shot report if one expired. A set first passes through the ms-to-seconds
// conversion. Depends on mcat_pkg, mcat_ms2s and mcat_cell.
`timescale 1ns / 1ps

module multi_channel_alarm_table_top #(
  parameter int CHANNELS = mcat_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcat_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcat_pkg::out_beat_t out_data
);
  import mcat_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;
  localparam logic [2:0] S_ONCE   = 3'd6;
  localparam logic [2:0] S_FINAL  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RPT_W-1:0] rpt_r, rpt_nxt;
  in_beat_t         req_r, req_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  logic              in_acc;
  logic              in_ok;
  logic              req_ok;
  logic              out_free;
  logic              emit;
  out_beat_t         emit_data;
  logic [SECS_W-1:0] secs;
  cell_cmd_t         cmd;
  cell_stat_t        stat_v [CHANNELS];
  chain_t            link [CHANNELS+1];
  chain_t            tail;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  s_idx;
  logic              a_conf;
  logic              a_run;
  logic [RPT_W-1:0]  limit;
  logic [2:0]        cell_op;

  // Seconds conversion for set
  mcat_ms2s u_ms2s (
    .clk  (clk),
    .ms   (req_r.interval_ms),
    .secs (secs)
  );

  // Row of channel cells
  assign link[0] = '0;
  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    mcat_cell #(.CH_INDEX(g)) u_ch (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .chain_in  (link[g]),
      .chain_out (link[g+1]),
      .stat      (stat_v[g])
    );
  end
  assign tail = link[CHANNELS];

  // Request decode and addressed-channel lookup
  always_comb begin
    in_ok  = (in_data.channel < CH_W'(CHANNELS));
    req_ok = (req_r.channel < CH_W'(CHANNELS));
    a_idx  = req_r.channel[IDX_W-1:0];
    s_idx  = cnt_r[IDX_W-1:0];
    a_conf = req_ok && stat_v[a_idx].configured;
    a_run  = req_ok && stat_v[a_idx].running;
    limit  = RPT_W'(MAX_RESULTS - 1) - RPT_W'(tail.once_v);
    unique case (req_r.req_type)
      REQ_SET:     cell_op = CELL_SET;
      REQ_CLEAR:   cell_op = CELL_CLEAR;
      REQ_ENABLE:  cell_op = CELL_ENABLE;
      REQ_DISABLE: cell_op = CELL_DISABLE;
      REQ_TICK:    cell_op = CELL_TICK;
      default:     cell_op = CELL_NOP;
    endcase
  end

  // Broadcast command; cells only act during the apply cycle
  always_comb begin
    cmd.op        = (state_r == S_APPLY) ? cell_op : CELL_NOP;
    cmd.channel   = req_r.channel;
    cmd.secs      = secs;
    cmd.periodic  = req_r.periodic;
    cmd.start_now = req_r.start_now;
    cmd.now       = req_r.now;
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rpt_nxt   = rpt_r;
    req_nxt   = req_r;
    emit      = 1'b0;
    emit_data = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_data;
          cnt_nxt = '0;
          rpt_nxt = '0;
          priority if (in_data.req_type > REQ_TRIP) begin
            state_nxt = S_RESULT;
          end else if (in_data.req_type == REQ_TICK) begin
            state_nxt = S_APPLY;
          end else if (!in_ok || in_data.req_type == REQ_TRIP) begin
            state_nxt = S_RESULT;
          end else if (in_data.req_type == REQ_SET) begin
            state_nxt = (in_data.interval_ms == '0) ? S_RESULT : S_DIV;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(2)) begin
          cnt_nxt   = '0;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CHANNELS)) begin
          cnt_nxt   = '0;
          state_nxt = (req_r.req_type == REQ_TICK) ? S_REPORT : S_RESULT;
        end
      end
      S_RESULT: begin
        emit_data.last = 1'b1;
        priority if (req_r.req_type > REQ_TRIP) begin
          emit_data.status = ST_OK;
        end else if (!req_ok) begin
          emit_data.status = ST_BAD_CH;
        end else if (req_r.req_type == REQ_TRIP) begin
          emit_data.fired         = a_conf;
          emit_data.fired_channel = a_conf ? req_r.channel : '0;
          emit_data.configured    = a_conf;
          emit_data.running_now   = a_run;
        end else if (req_r.req_type == REQ_SET && req_r.interval_ms == '0) begin
          emit_data.status = ST_BAD_INT;
        end else begin
          emit_data.configured  = a_conf;
          emit_data.running_now = a_run;
          emit_data.next_wait   = tail.min_wait;
        end
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REPORT: begin
        emit_data.fired         = 1'b1;
        emit_data.fired_channel = CH_W'(s_idx);
        emit_data.configured    = stat_v[s_idx].configured;
        emit_data.running_now   = stat_v[s_idx].running;
        emit_data.next_wait     = tail.min_wait;
        if (!(stat_v[s_idx].fire && rpt_r < limit) || out_free) begin
          if (stat_v[s_idx].fire && rpt_r < limit) begin
            emit    = 1'b1;
            rpt_nxt = rpt_r + RPT_W'(1);
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(CHANNELS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = tail.once_v ? S_ONCE : S_FINAL;
          end
        end
      end
      S_ONCE: begin
        emit_data.fired         = 1'b1;
        emit_data.fired_channel = tail.once_ch;
        emit_data.fired_once    = 1'b1;
        emit_data.next_wait     = tail.min_wait;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        emit_data.configured  = a_conf;
        emit_data.running_now = a_run;
        emit_data.next_wait   = tail.min_wait;
        emit_data.last        = 1'b1;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rpt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rpt_r       <= rpt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_rpt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rpt_r <= RPT_W'(MAX_RESULTS - 1))
    else $error("periodic report count over limit");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_data.last) |=> (state_r == S_IDLE))
    else $error("final beat did not return to idle");

  a_once_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fired_once) |->
      (out_data_r.fired && !out_data_r.configured && !out_data_r.running_now))
    else $error("one-shot report malformed");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.last && !out_data_r.fired && out_data_r.next_wait == '0))
    else $error("rejected request beat malformed");

  a_fired_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fired) |-> (out_data_r.fired_channel < CH_W'(CHANNELS)))
    else $error("fired channel out of range");

endmodule

[test/multi_channel_alarm_table_top_tb.sv]
// Self-checking testbench for multi_channel_alarm_table_top: directed and random
// alarm requests, with a predictor of the alarm table checking each result beat.
// Depends on mcat_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module multi_channel_alarm_table_top_tb;
  import mcat_pkg::*;

  localparam int NCH          = CHANNELS_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_REQS  = 400;
  localparam int DRAIN_CYCLES = 30;
  // Request codes the block does not define
  localparam logic [2:0] REQ_RSVD_LO = 3'd6;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  always #5 clk = ~clk;

  multi_channel_alarm_table_top #(.CHANNELS(NCH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Mirror of the alarm table
  logic [SECS_W-1:0] alarm_secs    [NCH];
  logic [TIME_W-1:0] alarm_expiry  [NCH];
  logic              alarm_periodic[NCH];
  logic              alarm_running [NCH];

  out_beat_t         pending_results[$];
  bit                steady = 1'b0;   // no idling on either side
  int                mismatches = 0;
  int                reqs_sent = 0;
  int                beats_checked = 0;
  int                firings_seen = 0;
  int                oneshots_seen = 0;
  int                cycle_count = 0;
  logic [TIME_W-1:0] sim_now;

  function automatic logic [TIME_W-1:0] add_sat32(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic void clear_alarm(int c);
    alarm_secs[c]     = '0;
    alarm_expiry[c]   = '0;
    alarm_periodic[c] = 1'b0;
    alarm_running[c]  = 1'b0;
  endfunction

  // Shortest wait over running channels; 0 when none run, else at least 1
  function automatic logic [SECS_W-1:0] shortest_wait(logic [TIME_W-1:0] now);
    logic [SECS_W-1:0] best;
    logic [TIME_W-1:0] w;
    int                i;
    best = '0;
    for (i = 0; i < NCH; i++) begin
      if (alarm_running[i]) begin
        w = (alarm_expiry[i] > now) ? alarm_expiry[i] - now : 32'd1;
        if (w > TIME_W'(MAX_SECS)) w = TIME_W'(MAX_SECS);
        if (best == 0 || w[SECS_W-1:0] < best) best = w[SECS_W-1:0];
      end
    end
    return best;
  endfunction

  function automatic out_beat_t result_beat(logic [1:0] st, logic f, logic [CH_W-1:0] ch,
                                            logic once, logic conf, logic run,
                                            logic [SECS_W-1:0] w, logic lst);
    out_beat_t r;
    r.status        = st;
    r.fired         = f;
    r.fired_channel = ch;
    r.fired_once    = once;
    r.configured    = conf;
    r.running_now   = run;
    r.next_wait     = w;
    r.last          = lst;
    return r;
  endfunction

  // Apply one request to the mirror and queue the beats it must produce
  function automatic void predict_alarm_results(in_beat_t b);
    logic              ok;
    logic              conf;
    logic              due[NCH];
    int                c;
    int                i;
    int                once_ch;
    int                lim;
    int                k;
    logic [31:0]       secs;
    logic [SECS_W-1:0] w;
    ok = b.channel < NCH;
    c  = ok ? int'(b.channel) : 0;
    if (b.req_type > REQ_TRIP) begin
      pending_results.push_back(result_beat(ST_OK, 0, 0, 0, 0, 0, 0, 1));
      return;
    end
    // Tick: periodic firings in index order, then highest one-shot, then final
    if (b.req_type == REQ_TICK) begin
      once_ch = -1;
      k = 0;
      for (i = 0; i < NCH; i++) begin
        due[i] = alarm_running[i] && alarm_expiry[i] <= b.now;
        if (due[i] && !alarm_periodic[i]) once_ch = i;
      end
      lim = MAX_RESULTS - 1 - ((once_ch >= 0) ? 1 : 0);
      for (i = 0; i < NCH; i++) begin
        if (due[i]) begin
          if (alarm_periodic[i]) alarm_expiry[i] = add_sat32(b.now, 32'(alarm_secs[i]));
          else clear_alarm(i);
        end
      end
      w = shortest_wait(b.now);
      for (i = 0; i < NCH; i++) begin
        if (due[i] && alarm_periodic[i] && k < lim) begin
          pending_results.push_back(result_beat(ST_OK, 1, CH_W'(i), 0, alarm_secs[i] != 0,
                                                alarm_running[i], w, 0));
          k++;
        end
      end
      if (once_ch >= 0)
        pending_results.push_back(result_beat(ST_OK, 1, CH_W'(once_ch), 1, 0, 0, w, 0));
      pending_results.push_back(result_beat(ST_OK, 0, 0, 0, ok && alarm_secs[c] != 0,
                                            ok && alarm_running[c], w, 1));
      return;
    end
    if (!ok) begin
      pending_results.push_back(result_beat(ST_BAD_CH, 0, 0, 0, 0, 0, 0, 1));
      return;
    end
    case (b.req_type)
      REQ_TRIP: begin
        conf = alarm_secs[c] != 0;
        pending_results.push_back(result_beat(ST_OK, conf, conf ? b.channel : '0, 0, conf,
                                              alarm_running[c], 0, 1));
        return;
      end
      REQ_SET: begin
        if (b.interval_ms == 0) begin
          pending_results.push_back(result_beat(ST_BAD_INT, 0, 0, 0, 0, 0, 0, 1));
          return;
        end
        // ms to whole seconds, rounding up
        secs = (32'(b.interval_ms) + 32'(MS_ROUND)) / 32'(MS_PER_S);
        alarm_secs[c]     = secs[SECS_W-1:0];
        alarm_expiry[c]   = add_sat32(b.now, secs);
        alarm_periodic[c] = b.periodic;
        alarm_running[c]  = b.start_now;
      end
      REQ_CLEAR: begin
        clear_alarm(c);
      end
      REQ_ENABLE: begin
        if (alarm_secs[c] != 0) alarm_running[c] = 1'b1;
      end
      default: begin
        alarm_running[c] = 1'b0;
      end
    endcase
    pending_results.push_back(result_beat(ST_OK, 0, 0, 0, alarm_secs[c] != 0,
                                          alarm_running[c], shortest_wait(b.now), 1));
  endfunction

  function automatic in_beat_t alarm_request(logic [2:0] op, int ch, logic [MS_W-1:0] ms,
                                             logic per, logic start,
                                             logic [TIME_W-1:0] now);
    in_beat_t b;
    b.req_type    = op;
    b.channel     = CH_W'(ch);
    b.interval_ms = ms;
    b.periodic    = per;
    b.start_now   = start;
    b.now         = now;
    return b;
  endfunction

  // Send one request beat; valid stays high until accepted
  task automatic send_request(input in_beat_t b);
    int gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(99) < 6) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_alarm_results(b);
    reqs_sent++;
  endtask

  // Hold off the sender until every expected beat is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Empty table: tick, trip and reserved requests
  task automatic test_idle_table();
    send_request(alarm_request(REQ_TICK, 0, 0, 0, 0, 0));
    send_request(alarm_request(REQ_TRIP, 0, 0, 0, 0, 0));
    send_request(alarm_request(REQ_RSVD_LO, 3, 5, 1, 1, 7));
    send_request(alarm_request(REQ_RSVD_HI, 255, '1, 1, 1, '1));
  endtask

  task automatic test_rejects();
    send_request(alarm_request(REQ_SET, NCH, 1000, 1, 1, 5));
    send_request(alarm_request(REQ_SET, 3, 0, 1, 1, 5));
    send_request(alarm_request(REQ_TRIP, 200, 0, 0, 0, 5));
    send_request(alarm_request(REQ_TICK, 255, 0, 0, 0, '1));
  endtask

  // Longest interval, expiry and wait saturation, tick at the top of time
  task automatic test_saturation();
    send_request(alarm_request(REQ_SET, 1, '1, 1, 1, '1));
    send_request(alarm_request(REQ_SET, 2, 1001, 0, 1, 32'hFFFF_0000));
    send_request(alarm_request(REQ_TICK, 1, 0, 0, 0, 0));
    send_request(alarm_request(REQ_TICK, 2, 0, 0, 0, '1));
  endtask

  task automatic test_set_control();
    send_request(alarm_request(REQ_SET, 0, 1, 1, 1, 100));
    send_request(alarm_request(REQ_SET, 7, 1000, 0, 0, 100));
    send_request(alarm_request(REQ_SET, 6, 999, 0, 1, 100));
    send_request(alarm_request(REQ_ENABLE, 7, 0, 0, 0, 100));
    // enable of an unconfigured channel is ignored
    send_request(alarm_request(REQ_ENABLE, 5, 0, 0, 0, 100));
    send_request(alarm_request(REQ_DISABLE, 0, 0, 0, 0, 100));
    send_request(alarm_request(REQ_ENABLE, 0, 0, 0, 0, 100));
    send_request(alarm_request(REQ_CLEAR, 4, 0, 0, 0, 100));
  endtask

  // Periodic fire plus two one-shots, of which only the higher is reported
  task automatic test_tick_fire();
    send_request(alarm_request(REQ_TICK, 7, 0, 0, 0, 101));
    send_request(alarm_request(REQ_TRIP, 0, 0, 0, 0, 101));
  endtask

  // Every channel fires in one tick: the longest result burst
  task automatic test_full_burst();
    int i;
    for (i = 1; i < NCH; i++)
      send_request(alarm_request(REQ_SET, i, MS_W'(1000 + i * 200), 1, 1, 1000));
    send_request(alarm_request(REQ_TICK, 0, 0, 0, 0, 5000));
  endtask

  // Mostly set/tick traffic on a slowly advancing clock, with some noise
  task automatic test_random_traffic(int count);
    in_beat_t b;
    int       n;
    int       r;
    sim_now = 6000;
    for (n = 0; n < count; n++) begin
      steady = (n >= 150 && n < 250);
      if (n % 80 == 79) wait_idle();
      sim_now += $urandom_range(4);
      r = $urandom_range(99);
      if (r < 3) sim_now = $urandom;
      else if (r < 5) sim_now = 32'hFFFF_FFFF - $urandom_range(20);
      b.now = sim_now;
      r = $urandom_range(99);
      b.req_type = (r < 25) ? REQ_SET : (r < 32) ? REQ_CLEAR : (r < 44) ? REQ_ENABLE :
                   (r < 52) ? REQ_DISABLE : (r < 88) ? REQ_TICK : (r < 97) ? REQ_TRIP :
                   r[0] ? REQ_RSVD_HI : REQ_RSVD_LO;
      b.channel = ($urandom_range(99) < 6) ? CH_W'($urandom_range(255, NCH))
                                           : CH_W'($urandom_range(NCH - 1));
      r = $urandom_range(99);
      b.interval_ms = (r < 4)  ? '0 :
                      (r < 16) ? MS_W'($urandom) :
                      (r < 50) ? MS_W'($urandom_range(3000, 1)) :
                                 MS_W'($urandom_range(15000, 1));
      b.periodic  = $urandom_range(1);
      b.start_now = $urandom_range(99) < 85;
      send_request(b);
    end
    steady = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("fired", want.fired, out_data.fired);
        check_field("fired_channel", want.fired_channel, out_data.fired_channel);
        check_field("fired_once", want.fired_once, out_data.fired_once);
        check_field("configured", want.configured, out_data.configured);
        check_field("running_now", want.running_now, out_data.running_now);
        check_field("next_wait", want.next_wait, out_data.next_wait);
        check_field("last", want.last, out_data.last);
        beats_checked++;
        if (want.fired && !want.last) firings_seen++;
        if (want.fired_once) oneshots_seen++;
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 6);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** multi_channel_alarm_table_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    for (i = 0; i < NCH; i++) clear_alarm(i);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_table();
    test_rejects();
    test_saturation();
    test_set_control();
    test_tick_fire();
    test_full_burst();
    wait_idle();
    test_random_traffic(RANDOM_REQS);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests (directed and random), %0d result beats checked.",
             reqs_sent, beats_checked);
    $display("Ticks reported %0d firings, %0d of them one-shot.",
             firings_seen, oneshots_seen);
    if (mismatches == 0) begin
      $display("** multi_channel_alarm_table_top: PASSED **");
    end else begin
      $display("** multi_channel_alarm_table_top: FAILED **");
    end
    $finish;
  end

endmodule
